// ----- src/c3pf_pkg.sv -----
// Shared types and constants of the 3x3 convolution pixel filter.
package c3pf_pkg;

    localparam int PIX_W   = 8;
    localparam int CHANNELS = 3;
    localparam int RGB_W   = PIX_W * CHANNELS;
    localparam int GEO_W   = 11;
    localparam int CNT_W   = 2 * GEO_W;
    localparam int SUM_W   = 21;
    localparam int MAG_W   = SUM_W - 1;
    localparam int DIV_W   = 11;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_MID = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BG_LEVEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd7;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MAC,
        ST_DINIT,
        ST_DIV,
        ST_DONE
    } t_state;

    // (r+g+b)/3 via reciprocal 683/2048, exact for sums up to 765
    function automatic logic [PIX_W-1:0] gray3(input logic [RGB_W-1:0] pix);
        logic [PIX_W+1:0] s;
        logic [PIX_W+11:0] m;
        s = {2'b00, pix[7:0]} + {2'b00, pix[15:8]} + {2'b00, pix[23:16]};
        m = {10'd0, s} * 20'd683;
        return m[PIX_W+10:11];
    endfunction

endpackage

// ----- src/conv3x3_pixel_filter.sv -----
// Top level of the 3x3 convolution pixel filter: line ring memory, MAC, divider.
//
//  channel | dir | beat fields
//  s_axis  | in  | tdata {blue,green,red}, tuser op
//  m_axis  | out | tdata {out_blue,out_green,out_red}, tlast last_pixel
//  cfg     | in  | i_cfg_index register number, i_cfg_data value; always ready
//
// Each beat passes through the check state; a beat that releases a result then makes
// 9 ring memory reads through the MAC pipeline, a divisor load, 20 restoring
// divider steps and a hand-over of the result to the output register.
// Reset is synchronous active low; the ring memory is not cleared.
// A result waiting on m_axis does not block the next input beat; only a new result
// waits until the output register is free.
module conv3x3_pixel_filter
    import c3pf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [RGB_W-1:0]     s_axis_tdata,   // red, green, blue
    input  logic                 s_axis_tuser,   // op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [RGB_W-1:0]     m_axis_tdata,   // out_red, out_green, out_blue
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RGB_W-1:0]     i_cfg_data
);

    localparam int DEPTH = 2 * MAX_WIDTH + 4;
    localparam int AW    = $clog2(DEPTH);

    // configuration
    logic [RGB_W-1:0] r_coef [3];
    logic [PIX_W-1:0] r_offset, r_bg;
    logic [1:0]       r_mode;
    logic [GEO_W-1:0] r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= 24'hFFFFFF;
            r_coef[1] <= 24'hFFF9FF;
            r_coef[2] <= 24'hFFFFFF;
            r_offset  <= 8'd128;
            r_bg      <= '0;
            r_mode    <= '0;
            r_width   <= 11'd640;
            r_height  <= 11'd480;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COEF_TOP: r_coef[0] <= i_cfg_data;
                REG_COEF_MID: r_coef[1] <= i_cfg_data;
                REG_COEF_BOT: r_coef[2] <= i_cfg_data;
                REG_OFFSET:   r_offset  <= i_cfg_data[PIX_W-1:0];
                REG_BG_LEVEL: r_bg      <= i_cfg_data[PIX_W-1:0];
                REG_MODE:     r_mode    <= i_cfg_data[1:0];
                REG_WIDTH:    r_width   <= i_cfg_data[GEO_W-1:0];
                REG_HEIGHT:   r_height  <= i_cfg_data[GEO_W-1:0];
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    // geometry
    logic [GEO_W-1:0] w_w, w_h;
    logic [CNT_W-1:0] w_count;
    assign w_w = (int'(r_width) > MAX_WIDTH) ? GEO_W'(MAX_WIDTH) : r_width;
    assign w_h = (int'(r_height) > MAX_HEIGHT) ? GEO_W'(MAX_HEIGHT) : r_height;
    assign w_count = CNT_W'(w_w) * CNT_W'(w_h);

    // control state
    t_state r_state, n_state;
    logic [CNT_W-1:0] r_in_cnt, r_out_cnt;
    logic [AW-1:0]    r_wptr, r_optr;
    logic [3:0]       r_tap;
    logic [1:0]       r_k, r_l;
    logic [4:0]       r_step;
    logic             r_oor, r_last;

    logic w_accept, w_we, w_release, w_out_free;
    logic [CNT_W:0] w_pw1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_we = w_accept && (s_axis_tuser == OP_PIXEL) && (r_in_cnt < w_count);
    assign w_pw1 = {1'b0, r_out_cnt} + (CNT_W+1)'(w_w) + 1'b1;
    assign w_release = (r_out_cnt < r_in_cnt) &&
                       ((w_pw1 < {1'b0, r_in_cnt}) || (w_pw1 >= {1'b0, w_count}));
    assign w_out_free = !m_axis_tvalid || m_axis_tready;

    logic r_v1, r_v2;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_CHECK;
            ST_CHECK: n_state = w_release ? ST_MAC : ST_IDLE;
            ST_MAC:   if (r_tap == 4'd9 && !r_v1 && !r_v2) n_state = ST_DINIT;
            ST_DINIT: n_state = ST_DIV;
            ST_DIV:   if (r_step == 5'(MAG_W - 1)) n_state = ST_DONE;
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // ring memory
    logic [RGB_W-1:0] mem [DEPTH];
    logic [RGB_W-1:0] r_rd_data;
    logic [AW-1:0]    w_raddr, r_base;
    logic [AW+1:0]    w_asum;
    logic [AW:0]      w_bdiff;

    assign w_bdiff = {1'b0, r_optr} - (AW+1)'(w_w) - 1'b1;
    assign w_asum = {2'b00, r_base}
                  + ((r_k == 2'd2) ? (AW+2)'({w_w, 1'b0}) :
                     (r_k == 2'd1) ? (AW+2)'(w_w) : '0)
                  + (AW+2)'(r_l);
    assign w_raddr = (w_asum >= (AW+2)'(DEPTH)) ? AW'(w_asum - (AW+2)'(DEPTH))
                                                : w_asum[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_we) mem[r_wptr] <= s_axis_tdata;
        r_rd_data <= mem[w_raddr];
    end

    // counters and address sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
            r_wptr    <= '0;
            r_optr    <= '0;
            r_tap     <= '0;
            r_k       <= '0;
            r_l       <= '0;
        end else begin
            if (w_we) begin
                r_in_cnt <= r_in_cnt + 1'b1;
                r_wptr   <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (r_state == ST_CHECK) begin
                r_tap <= '0;
                r_k   <= '0;
                r_l   <= '0;
            end else if (r_state == ST_MAC && r_tap != 4'd9) begin
                r_tap <= r_tap + 1'b1;
                if (r_l == 2'd2) begin
                    r_l <= '0;
                    r_k <= r_k + 1'b1;
                end else begin
                    r_l <= r_l + 1'b1;
                end
            end
            if (r_state == ST_DONE && w_out_free) begin
                if (r_last) begin
                    r_in_cnt  <= '0;
                    r_out_cnt <= '0;
                    r_wptr    <= '0;
                    r_optr    <= '0;
                end else begin
                    r_out_cnt <= r_out_cnt + 1'b1;
                    r_optr    <= (r_optr == AW'(DEPTH - 1)) ? '0 : r_optr + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CHECK) begin
            r_base <= w_bdiff[AW] ? AW'(w_bdiff + (AW+1)'(DEPTH)) : w_bdiff[AW-1:0];
            r_oor  <= (r_out_cnt < CNT_W'(w_w) + 1'b1) || (w_pw1 >= {1'b0, w_count});
            r_last <= ({1'b0, r_out_cnt} + 1'b1) >= {1'b0, w_count};
        end
    end

    // MAC pipeline: memory data, channel value, multiply-accumulate
    logic [3:0]             r_t1, r_t2;
    logic [PIX_W-1:0]       r_val [CHANNELS];
    logic [PIX_W-1:0]       r_cgray;
    logic signed [SUM_W-1:0] r_acc [CHANNELS];
    logic [PIX_W-1:0]       w_gray, w_coef;
    logic signed [PIX_W:0]  w_sval [CHANNELS];
    logic signed [2*PIX_W:0] w_prod [CHANNELS];

    assign w_gray = gray3(r_rd_data);

    always_comb begin
        case (r_t2)
            4'd0:    w_coef = r_coef[0][7:0];
            4'd1:    w_coef = r_coef[0][15:8];
            4'd2:    w_coef = r_coef[0][23:16];
            4'd3:    w_coef = r_coef[1][7:0];
            4'd4:    w_coef = r_coef[1][15:8];
            4'd5:    w_coef = r_coef[1][23:16];
            4'd6:    w_coef = r_coef[2][7:0];
            4'd7:    w_coef = r_coef[2][15:8];
            default: w_coef = r_coef[2][23:16];
        endcase
    end

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_sval[c] = $signed({1'b0, r_val[c]});
            w_prod[c] = w_sval[c] * $signed(w_coef);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= (r_state == ST_MAC) && (r_tap != 4'd9);
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t1 <= r_tap;
        r_t2 <= r_t1;
        if (r_v1) begin
            for (int c = 0; c < CHANNELS; c++)
                r_val[c] <= (r_mode != 2'd0) ? w_gray : r_rd_data[c*PIX_W +: PIX_W];
            if (r_t1 == 4'd4) r_cgray <= w_gray;
        end
        for (int c = 0; c < CHANNELS; c++) begin
            if (r_state == ST_CHECK) r_acc[c] <= '0;
            else if (r_v2)           r_acc[c] <= r_acc[c] + SUM_W'(w_prod[c]);
        end
    end

    // divisor: |sum of coefficients|, 1 when zero
    logic signed [DIV_W+1:0] w_csum;
    logic [DIV_W-1:0]        w_div;
    always_comb begin
        w_csum = '0;
        for (int k = 0; k < 3; k++)
            for (int l = 0; l < 3; l++)
                w_csum = w_csum + (DIV_W+2)'($signed(r_coef[k][l*PIX_W +: PIX_W]));
        w_div = w_csum[DIV_W+1] ? DIV_W'(-w_csum) : DIV_W'(w_csum);
        if (w_div == '0) w_div = DIV_W'(1);
    end

    // restoring divider, three lanes sharing one step counter
    logic [DIV_W-1:0] r_dvs;
    logic [DIV_W:0]   r_rem [CHANNELS];
    logic [MAG_W-1:0] r_quo [CHANNELS];
    logic             r_neg [CHANNELS];
    logic [DIV_W+1:0] w_trial [CHANNELS];
    logic signed [SUM_W-1:0] w_s [CHANNELS];

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_s[c] = r_oor ? SUM_W'(255) : r_acc[c];
            w_trial[c] = {r_rem[c], r_quo[c][MAG_W-1]} - (DIV_W+2)'(r_dvs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DINIT) begin
            r_dvs  <= w_div;
            r_step <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_neg[c] <= w_s[c][SUM_W-1];
                r_quo[c] <= w_s[c][SUM_W-1] ? MAG_W'(-w_s[c]) : MAG_W'(w_s[c]);
                r_rem[c] <= '0;
            end
        end else if (r_state == ST_DIV) begin
            r_step <= r_step + 1'b1;
            for (int c = 0; c < CHANNELS; c++) begin
                if (!w_trial[c][DIV_W+1]) begin
                    r_rem[c] <= w_trial[c][DIV_W:0];
                    r_quo[c] <= {r_quo[c][MAG_W-2:0], 1'b1};
                end else begin
                    r_rem[c] <= {r_rem[c][DIV_W-1:0], r_quo[c][MAG_W-1]};
                    r_quo[c] <= {r_quo[c][MAG_W-2:0], 1'b0};
                end
            end
        end
    end

    // offset, clamp, background removal
    logic [PIX_W-1:0] w_res [CHANNELS];
    logic signed [SUM_W:0] w_q [CHANNELS];
    logic signed [SUM_W:0] w_t [CHANNELS];
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            w_q[c] = r_neg[c] ? -$signed({2'b00, r_quo[c]}) : $signed({2'b00, r_quo[c]});
            w_t[c] = w_q[c] + $signed({{(SUM_W+1-PIX_W){1'b0}}, r_offset});
            if (r_mode[1] && w_q[c] == '0 && r_cgray == r_bg) w_res[c] = PIX_MAX;
            else if (w_t[c] < 0)                               w_res[c] = '0;
            else if (w_t[c] > $signed((SUM_W+1)'(255)))        w_res[c] = PIX_MAX;
            else                                              w_res[c] = w_t[c][PIX_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            m_axis_tdata <= {w_res[2], w_res[1], w_res[0]};
            m_axis_tlast <= r_last;
        end
    end

endmodule

// ----- src/c3pf_checker.sv -----
// Port-level checks of the 3x3 convolution pixel filter, bound to the top level.
module c3pf_checker
    import c3pf_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [RGB_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast,
    input logic             o_cfg_ready
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    // one beat at a time: input closes right after a beat is taken
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accept");

    // a result never appears the cycle after an input beat
    a_no_fast_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result too early");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind conv3x3_pixel_filter c3pf_checker u_c3pf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .o_cfg_ready   (o_cfg_ready)
);

// ----- test/conv3x3_pixel_filter_tb.sv -----
// Self-checking testbench of the 3x3 convolution pixel filter: random images and stalls.
`timescale 1ns / 100ps

module conv3x3_pixel_filter_tb;
    import c3pf_pkg::*;

    localparam int RING_DEPTH = 2052;
    localparam int SIZE_MAX   = 1024;
    localparam int IDLE_LIMIT = 6000;
    localparam int SETTLE_CYC = 60;

    typedef struct packed {
        logic             op;
        logic [RGB_W-1:0] pix;
    } t_pix_beat;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        logic             last;
    } t_filt_out;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [RGB_W-1:0]     s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [RGB_W-1:0]     m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [RGB_W-1:0]     i_cfg_data;

    conv3x3_pixel_filter uut (.*);

    // shadow of the filter
    logic [RGB_W-1:0] sh_coef [3];
    logic [7:0]       sh_offset, sh_bg;
    logic [1:0]       sh_mode;
    logic [10:0]      sh_width, sh_height;
    logic [RGB_W-1:0] ring_mem [RING_DEPTH];
    int unsigned      pix_in_cnt, pix_out_cnt;

    t_pix_beat feed_q [$];
    t_filt_out filt_q [$];
    t_pix_beat cur_beat;
    int        burst_left, gap_left;
    int        stall_left, rx_phase;
    bit        long_stall_req;
    int        n_errors, n_items, idle_cycles;

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int coef_of(int row, int col);
        return int'($signed(sh_coef[row][8*col +: 8]));
    endfunction

    function automatic int gray_of(logic [RGB_W-1:0] pix);
        return (int'(pix[7:0]) + int'(pix[15:8]) + int'(pix[23:16])) / 3;
    endfunction

    // advance the shadow by one accepted beat and queue the result it releases
    task automatic filter_step(logic op, logic [RGB_W-1:0] pix);
        int unsigned w, h, cnt, p, base, nb;
        int csum, dv, s, v;
        int res [3];
        bit oor;
        t_filt_out e;
        w = (sh_width > SIZE_MAX) ? SIZE_MAX : sh_width;
        h = (sh_height > SIZE_MAX) ? SIZE_MAX : sh_height;
        cnt = w * h;
        if (op == OP_PIXEL && pix_in_cnt < cnt) begin
            ring_mem[pix_in_cnt % RING_DEPTH] = pix;
            pix_in_cnt++;
        end
        p = pix_out_cnt;
        if (!(p < pix_in_cnt && (p + w + 1 < pix_in_cnt || p + w + 1 >= cnt)))
            return;
        csum = 0;
        for (int k = 0; k < 3; k++)
            for (int l = 0; l < 3; l++)
                csum += coef_of(k, l);
        dv = (csum < 0) ? -csum : csum;
        if (dv == 0) dv = 1;
        oor = (p < w + 1) || (p + w + 1 >= cnt);
        for (int c = 0; c < 3; c++) begin
            s = 0;
            if (oor) begin
                s = 255;
            end else begin
                base = p - (w + 1);
                for (int k = 0; k < 3; k++)
                    for (int l = 0; l < 3; l++) begin
                        nb = (base + k * w + l) % RING_DEPTH;
                        v = (sh_mode != 0) ? gray_of(ring_mem[nb])
                                           : int'(ring_mem[nb][8*c +: 8]);
                        s += v * coef_of(k, l);
                    end
            end
            s = s / dv;
            if (sh_mode >= 2 && s == 0 && gray_of(ring_mem[p % RING_DEPTH]) == int'(sh_bg)) begin
                s = 255;
            end else begin
                s += int'(sh_offset);
                if (s > 255) s = 255;
                if (s < 0) s = 0;
            end
            res[c] = s;
        end
        if (sh_mode != 0) begin
            res[1] = res[0];
            res[2] = res[0];
        end
        e.r = res[0][7:0];
        e.g = res[1][7:0];
        e.b = res[2][7:0];
        e.last = (p + 1 >= cnt);
        filt_q.push_back(e);
        pix_out_cnt++;
        if (e.last) begin
            pix_in_cnt = 0;
            pix_out_cnt = 0;
        end
    endtask

    // pixel source: bursts of random length with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= OP_PIXEL;
            burst_left <= 1;
            gap_left <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                filter_step(s_axis_tuser, s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (feed_q.size() > 0) begin
                    cur_beat = feed_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= cur_beat.pix;
                    s_axis_tuser <= cur_beat.op;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge i_clk) begin
        t_filt_out e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
            rx_phase <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (filt_q.size() == 0) begin
                    $display("%0t: unexpected result beat %h last %b", $time,
                             m_axis_tdata, m_axis_tlast);
                    n_errors++;
                end else begin
                    e = filt_q.pop_front();
                    if (m_axis_tdata[7:0] !== e.r) begin
                        $display("%0t: out_red expected %0d got %0d", $time, e.r,
                                 m_axis_tdata[7:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[15:8] !== e.g) begin
                        $display("%0t: out_green expected %0d got %0d", $time, e.g,
                                 m_axis_tdata[15:8]);
                        n_errors++;
                    end
                    if (m_axis_tdata[23:16] !== e.b) begin
                        $display("%0t: out_blue expected %0d got %0d", $time, e.b,
                                 m_axis_tdata[23:16]);
                        n_errors++;
                    end
                    if (m_axis_tlast !== e.last) begin
                        $display("%0t: last_pixel expected %b got %b", $time, e.last,
                                 m_axis_tlast);
                        n_errors++;
                    end
                end
            end
            rx_phase <= rx_phase + 1;
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end else if (long_stall_req) begin
                long_stall_req = 1'b0;
                stall_left <= 400;
                m_axis_tready <= 1'b0;
            end else if (rx_phase[8]) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= (rx_phase[3:0] < 4'd5) ? 1'b0 : ($urandom_range(0, 3) != 0);
            end
        end
    end

    // watchdog: cycles without any beat
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_beat(logic op, logic [RGB_W-1:0] pix);
        feed_q.push_back('{op: op, pix: pix});
        n_items++;
    endtask

    // wait until every beat went in and every result came out, then let the block settle
    task automatic settle();
        do @(posedge i_clk);
        while (feed_q.size() != 0 || s_axis_tvalid || filt_q.size() != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic configure(logic [23:0] top, logic [23:0] mid, logic [23:0] bot,
                             logic [7:0] ofs, logic [7:0] bg, logic [1:0] md,
                             logic [10:0] w, logic [10:0] h);
        logic [23:0] vals [8];
        vals = '{top, mid, bot, {16'd0, ofs}, {16'd0, bg}, {22'd0, md}, {13'd0, w}, {13'd0, h}};
        for (int i = 0; i < 8; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data <= vals[i];
            do @(posedge i_clk);
            while (!o_cfg_ready);
            case (CFG_IDX_W'(i))
                REG_COEF_TOP: sh_coef[0] = vals[i];
                REG_COEF_MID: sh_coef[1] = vals[i];
                REG_COEF_BOT: sh_coef[2] = vals[i];
                REG_OFFSET:   sh_offset = vals[i][7:0];
                REG_BG_LEVEL: sh_bg = vals[i][7:0];
                REG_MODE:     sh_mode = vals[i][1:0];
                REG_WIDTH:    sh_width = vals[i][10:0];
                REG_HEIGHT:   sh_height = vals[i][10:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // flush out the tail of the current image
    task automatic drain_image();
        while (pix_in_cnt != 0 || pix_out_cnt != 0) begin
            if (feed_q.size() == 0 && !s_axis_tvalid)
                push_beat(OP_FLUSH, '0);
            @(posedge i_clk);
        end
        settle();
    endtask

    // one image of npix pixels; flat images sit near one gray level
    task automatic random_image(int npix, bit flat, logic [7:0] level);
        logic [RGB_W-1:0] pix;
        for (int i = 0; i < npix; i++) begin
            if ($urandom_range(0, 7) == 0)
                push_beat(OP_FLUSH, RGB_W'($urandom));
            if (flat && $urandom_range(0, 5) != 0)
                pix = {level, level, level};
            else
                pix = RGB_W'($urandom);
            push_beat(OP_PIXEL, pix);
        end
        drain_image();
    endtask

    function automatic logic [23:0] random_row();
        case ($urandom_range(0, 5))
            0: return 24'hFFFFFF;
            1: return 24'h7F7F7F;
            2: return 24'h808080;
            3: return 24'h000000;
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        int w, h;
        logic [7:0] lvl;
        bit stall_sent;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_PIXEL;
        m_axis_tready = 1'b0;
        long_stall_req = 1'b0;
        stall_sent = 1'b0;
        n_errors = 0;
        n_items = 0;
        idle_cycles = 0;
        sh_coef = '{24'hFFFFFF, 24'hFFF9FF, 24'hFFFFFF};
        sh_offset = 8'd128;
        sh_bg = 8'd0;
        sh_mode = 2'd0;
        sh_width = 11'd640;
        sh_height = 11'd480;
        pix_in_cnt = 0;
        pix_out_cnt = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 3x3 colour image with extreme values, early flushes, pixels past a full image
        configure(24'hFFFFFF, 24'hFFF9FF, 24'hFFFFFF, 8'd128, 8'd0, 2'd0, 11'd3, 11'd3);
        push_beat(OP_FLUSH, 24'hFFFFFF);
        push_beat(OP_PIXEL, 24'h000000);
        push_beat(OP_PIXEL, 24'hFFFFFF);
        push_beat(OP_PIXEL, 24'hAA55AA);
        push_beat(OP_FLUSH, 24'h000000);
        push_beat(OP_PIXEL, 24'h55AA55);
        push_beat(OP_PIXEL, 24'hFF00FF);
        push_beat(OP_PIXEL, 24'h00FF00);
        push_beat(OP_PIXEL, 24'h0F0F0F);
        push_beat(OP_PIXEL, 24'hF0F0F0);
        push_beat(OP_PIXEL, 24'h123456);
        push_beat(OP_PIXEL, 24'hFFFFFF);
        push_beat(OP_PIXEL, 24'h000000);
        drain_image();
        // gray with largest coefficients, zero offset
        configure(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 8'd0, 8'd255, 2'd1, 11'd3, 11'd4);
        random_image(12, 0, 8'd0);
        // background removal with a zero-sum kernel on a flat image, mode 3 as well
        configure(24'hFFFFFF, 24'hFF08FF, 24'hFFFFFF, 8'd255, 8'd77, 2'd2, 11'd4, 11'd4);
        random_image(16, 1, 8'd77);
        configure(24'h808080, 24'h808080, 24'h808080, 8'd200, 8'd0, 2'd3, 11'd3, 11'd3);
        random_image(9, 1, 8'd0);
        // zero size: pixels are ignored
        configure(24'h000000, 24'h000000, 24'h000000, 8'd10, 8'd0, 2'd0, 11'd0, 11'd5);
        push_beat(OP_PIXEL, 24'hFFFFFF);
        push_beat(OP_FLUSH, 24'h000000);
        push_beat(OP_PIXEL, 24'h000000);
        settle();

        // random images; one of them with a long receiver hold-off
        while (n_items < 900) begin
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            lvl = 8'($urandom);
            configure(random_row(), random_row(), random_row(), 8'($urandom), lvl,
                      2'($urandom_range(0, 3)), 11'(w), 11'(h));
            if (!stall_sent && n_items > 400) begin
                long_stall_req = 1'b1;
                stall_sent = 1'b1;
            end
            random_image(w * h, $urandom_range(0, 2) == 0, lvl);
        end

        settle();
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/c3pf_pkg.sv
src/conv3x3_pixel_filter.sv
src/c3pf_checker.sv
test/conv3x3_pixel_filter_tb.sv
